[hw/rtl/htsc_pkg.sv]
// Shared types and constants for the hashed tiny-string cache.
// Used by htsc_store and hashed_tiny_string_cache_unit; no dependencies.
package htsc_pkg;

    localparam int SLOTS     = 256;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int MAX_UNITS = 4;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;   // prime = 2^40 + 0x1b3
    localparam int          FNV_PRIME_SHIFT = 40;

    typedef struct packed {
        logic [2:0]  unit_count;
        logic [15:0] unit_a;
        logic [15:0] unit_b;
        logic [15:0] unit_c;
        logic [15:0] unit_d;
    } htsc_cmd_t;

    typedef struct packed {
        logic        hit;
        logic [7:0]  slot;
        logic        displaced;
        logic [63:0] digest;
    } htsc_result_t;

    typedef struct packed {
        logic [2:0]  count;
        logic [63:0] units;
    } htsc_entry_t;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [SLOT_W-1:0] addr;
        htsc_entry_t       wdata;
    } htsc_store_req_t;

endpackage

[hw/rtl/htsc_store.sv]
// Slot table: entry memory with registered read plus per-slot valid flops.
// Depends on htsc_pkg.
module htsc_store
    import htsc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  htsc_store_req_t req,
    output htsc_entry_t     rd_entry,
    output logic            rd_valid
);

    htsc_entry_t       mem [SLOTS];
    htsc_entry_t       rd_entry_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rd_entry_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

[hw/rtl/hashed_tiny_string_cache_unit.sv]
// Top level of the hashed tiny-string cache: sequencer, FNV-1a hash unit, result register.
// Depends on htsc_pkg and htsc_store.
//
// A transaction is taken when start is high and busy is low. The string is hashed one
// byte per cycle through a single 64-bit FNV-1a step (xor, then multiply by the prime as
// a 40-bit shift plus a 9-bit multiply), then the slot is read and compared, and on a
// miss the slot is rewritten. The done strobe is raised from the compare state; busy drops
// in the cycle done is high, so the next start may be taken then. The result is shown
// for exactly one cycle with done high and cannot be held off by the receiver.
module hashed_tiny_string_cache_unit
    import htsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  htsc_cmd_t    cmd,
    output logic         busy,
    output logic         done,
    output htsc_result_t result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HASH = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_CMP  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [2:0]      step_reg, step_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [63:0]     units_reg, units_next;
    logic [63:0]     hash_reg, hash_next;
    logic            done_reg, done_next;
    htsc_result_t    result_reg, result_next;

    logic [2:0]      cnt_sat;
    logic [63:0]     cmd_units;
    logic [63:0]     cmd_packed;
    logic [15:0]     cur_unit;
    logic [7:0]      cur_byte;
    logic [63:0]     mix;
    logic [63:0]     hash_step;
    logic            last_byte;
    logic            hit;

    htsc_store_req_t store_req;
    htsc_entry_t     store_entry;
    logic            store_valid;

    htsc_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (store_req),
        .rd_entry (store_entry),
        .rd_valid (store_valid)
    );

    assign cnt_sat   = (cmd.unit_count > 3'(MAX_UNITS)) ? 3'(MAX_UNITS) : cmd.unit_count;
    assign cmd_units = {cmd.unit_d, cmd.unit_c, cmd.unit_b, cmd.unit_a};

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cmd_packed[16*k +: 16] = (3'(k) < cnt_sat) ? cmd_units[16*k +: 16] : 16'h0000;
        end
    end

    // shared hash unit: one FNV-1a byte step
    assign cur_unit  = units_reg[{step_reg[2:1], 4'b0000} +: 16];
    assign cur_byte  = step_reg[0] ? cur_unit[15:8] : cur_unit[7:0];
    assign mix       = hash_reg ^ {56'h0, cur_byte};
    assign hash_step = (mix << FNV_PRIME_SHIFT) + (mix * {55'h0, FNV_PRIME_LO});
    assign last_byte = ({1'b0, step_reg} + 4'd1) == {cnt_reg, 1'b0};

    assign hit = store_valid && (store_entry.count == cnt_reg)
                 && (store_entry.units == units_reg);

    always_comb
    begin
        store_req.rd          = (state_reg == ST_READ);
        store_req.wr          = (state_reg == ST_CMP) && !hit;
        store_req.addr        = hash_reg[SLOT_W-1:0];
        store_req.wdata.count = cnt_reg;
        store_req.wdata.units = units_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        units_next  = units_reg;
        hash_next   = hash_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = cnt_sat;
                    units_next = cmd_packed;
                    hash_next  = FNV_BASIS;
                    step_next  = 3'd0;
                    state_next = (cnt_sat == 3'd0) ? ST_READ : ST_HASH;
                end
            end
            ST_HASH:
            begin
                hash_next = hash_step;
                step_next = step_reg + 3'd1;
                if (last_byte)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                done_next             = 1'b1;
                result_next.hit       = hit;
                result_next.slot      = 8'(hash_reg[SLOT_W-1:0]);
                result_next.displaced = !hit && store_valid;
                result_next.digest    = hash_reg;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        units_reg  <= units_next;
        hash_reg   <= hash_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_hit_not_displaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.hit && result.displaced))
        else $error("hit reported together with displaced");

    a_done_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |=> (done && !busy))
        else $error("compare state did not finish transaction");
`endif

endmodule

[verif/tb_hashed_tiny_string_cache_unit.sv]
// Self-checking testbench for hashed_tiny_string_cache_unit: directed table, then random strings.
// Depends on htsc_pkg and the cache RTL; results are checked against a behavioral cache model.
module tb_hashed_tiny_string_cache_unit;
    import htsc_pkg::*;

    localparam logic [63:0] PRIME        = 64'h100000001b3;
    localparam int          RANDOM_ITEMS = 400;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          SETTLE       = 16;
    localparam int          POOL         = 16;

    typedef struct {
        htsc_cmd_t    cmd;
        bit           pinned;
        htsc_result_t res;
    } string_row_t;

    typedef struct {
        bit           pinned;
        htsc_result_t res;
    } pinned_result_t;

    logic         clk;
    logic         rst_n;
    logic         start;
    htsc_cmd_t    cmd;
    logic         busy;
    logic         done;
    htsc_result_t result;

    // model copy of the table
    bit          line_valid[SLOTS];
    logic [2:0]  line_len[SLOTS];
    logic [63:0] line_units[SLOTS];

    htsc_result_t   lookup_q[$];
    pinned_result_t pinned_q[$];
    int             failures = 0;
    int             cycles   = 0;
    bit             no_idle  = 1'b0;
    htsc_cmd_t      recent[POOL];
    int             recent_n = 0;

    // empty strings hash to the offset basis, slot 0x25
    string_row_t directed[19] = '{
        '{'{3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b0, 8'h25, 1'b0, 64'hcbf29ce484222325}},
        '{'{3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{1'b1, 8'h25, 1'b0, 64'hcbf29ce484222325}},
        '{'{3'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{3'd1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{3'd1, 16'hFFFF, 16'h1111, 16'h2222, 16'h3333}, 1'b0, '0},
        '{'{3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{3'd4, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{3'd5, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0}, 1'b0, '0},
        '{'{3'd7, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0}, 1'b0, '0},
        '{'{3'd4, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0}, 1'b0, '0},
        '{'{3'd6, 16'h1234, 16'h5678, 16'h9abc, 16'hdef1}, 1'b0, '0},
        '{'{3'd2, 16'h0001, 16'h8000, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{3'd2, 16'h0001, 16'h8000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{3'd3, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0},
        '{'{3'd3, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h0000}, 1'b0, '0},
        '{'{3'd1, 16'h0100, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{3'd1, 16'h0001, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{3'd2, 16'h0001, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0}
    };

    hashed_tiny_string_cache_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic htsc_result_t cache_lookup(htsc_cmd_t c);
        logic [15:0]  u[4];
        logic [63:0]  h;
        logic [63:0]  units_word;
        int           n;
        htsc_result_t r;
        u = '{c.unit_a, c.unit_b, c.unit_c, c.unit_d};
        n = (c.unit_count > MAX_UNITS) ? MAX_UNITS : int'(c.unit_count);
        h = FNV_BASIS;
        units_word = '0;
        for (int i = 0; i < n; i++)
        begin
            h = (h ^ {56'd0, u[i][7:0]}) * PRIME;
            h = (h ^ {56'd0, u[i][15:8]}) * PRIME;
            units_word |= {48'd0, u[i]} << (16 * i);
        end
        r.slot      = h[7:0];
        r.digest    = h;
        r.hit       = line_valid[r.slot] && line_len[r.slot] == n
                      && line_units[r.slot] == units_word;
        r.displaced = 1'b0;
        if (!r.hit)
        begin
            r.displaced           = line_valid[r.slot];
            line_valid[r.slot]    = 1'b1;
            line_len[r.slot]      = 3'(n);
            line_units[r.slot]    = units_word;
        end
        return r;
    endfunction

    function automatic logic [15:0] random_unit();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 255));
            3:       return 16'($urandom_range(0, 255)) << 8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            failures++;
            if (failures <= 10)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endfunction

    task automatic send_string(htsc_cmd_t c, bit pinned, htsc_result_t res);
        pinned_q.push_back('{pinned, res});
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic idle_gap();
        int                           n;
        int                           pick;
        logic [$bits(htsc_cmd_t)-1:0] noise;
        if (no_idle)
            return;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            n = 0;
        else if (pick < 18)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 40);
        if (n == 0)
            return;
        start <= 1'b0;
        for (int k = 0; k < n; k++)
        begin
            noise = {3'($urandom), $urandom, $urandom};
            cmd <= noise;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (lookup_q.size() != 0)
            @(posedge clk);
    endtask

    // results first: a result never belongs to a transaction taken at the same edge
    always @(posedge clk)
    begin
        pinned_result_t pin;
        htsc_result_t   want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (lookup_q.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result: %p", result);
                end
                else
                begin
                    want = lookup_q.pop_front();
                    check_field("hit", want.hit, result.hit);
                    check_field("slot", want.slot, result.slot);
                    check_field("displaced", want.displaced, result.displaced);
                    check_field("digest", want.digest, result.digest);
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                pin  = pinned_q.pop_front();
                want = cache_lookup(cmd);
                lookup_q.push_back(pin.pinned ? pin.res : want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** hashed_tiny_string_cache_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        htsc_cmd_t c;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        foreach (line_valid[i])
            line_valid[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_string(directed[i].cmd, directed[i].pinned, directed[i].res);
            idle_gap();
        end
        drain();

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (recent_n > 0 && $urandom_range(0, 9) < 4)
            begin
                // revisit a recent string, possibly with a saturated count or junk past the end
                c = recent[$urandom_range(0, recent_n - 1)];
                if (c.unit_count >= MAX_UNITS)
                    c.unit_count = 3'($urandom_range(MAX_UNITS, 7));
                else if ($urandom_range(0, 1) == 1)
                begin
                    c.unit_d = random_unit();
                    if (c.unit_count < 3)
                        c.unit_c = random_unit();
                    if (c.unit_count < 2)
                        c.unit_b = random_unit();
                    if (c.unit_count < 1)
                        c.unit_a = random_unit();
                end
            end
            else
            begin
                c.unit_count = 3'($urandom_range(0, 7));
                c.unit_a     = random_unit();
                c.unit_b     = random_unit();
                c.unit_c     = random_unit();
                c.unit_d     = random_unit();
                if (recent_n < POOL)
                begin
                    recent[recent_n] = c;
                    recent_n++;
                end
                else
                    recent[$urandom_range(0, POOL - 1)] = c;
            end
            send_string(c, 1'b0, '0);
            if ($urandom_range(0, 39) == 0)
                drain();
            else
                idle_gap();
        end

        start <= 1'b0;
        while (lookup_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (failures == 0 && lookup_q.size() == 0)
            $display("** hashed_tiny_string_cache_unit: PASSED **");
        else
            $display("** hashed_tiny_string_cache_unit: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/htsc_pkg.sv
hw/rtl/htsc_store.sv
hw/rtl/hashed_tiny_string_cache_unit.sv
verif/tb_hashed_tiny_string_cache_unit.sv
